// ===== sv/r48bw_pkg.sv =====
// Package for the rand48 byte whitener with reseed.
// Holds the operation codes, sequencer states, LCG and hash constants.
// No dependencies.
package r48bw_pkg;

  localparam int unsigned SeedW = 48;
  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned CrankW = 5;
  localparam int unsigned LoopW = 6;   // crank_count + 3, up to 34

  localparam logic [63:0] LcgMul = 64'h0000_0005_DEEC_E66D;
  localparam logic [47:0] LcgAdd = 48'h0000_0000_000B;
  localparam logic [63:0] HMul   = 64'hC6A4_A793_5BD1_E995;
  localparam int unsigned HShift = 47;

  localparam logic [15:0] BaseC0 = 16'h330E;
  localparam logic [15:0] BaseC1 = 16'hABCD;
  localparam logic [15:0] BaseC2 = 16'h1234;

  localparam logic [LoopW-1:0] CrankExtra = LoopW'(3);

  typedef enum logic [1:0] {
    OpBase   = 2'd0,
    OpReseed = 2'd1,
    OpData   = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StPost = 4'b0100,
    StDone = 4'b1000
  } state_e;

  // Murmur2 style finalizer, evaluated at elaboration only.
  function automatic logic [63:0] hmix_c(input logic [63:0] v);
    logic [63:0] t;
    t = v * HMul;
    t = t ^ (t >> HShift);
    return t * HMul;
  endfunction

  // Hash state after folding in the length word of an 8-byte key.
  localparam logic [63:0] HashInit = hmix_c(64'd8) * HMul;

endpackage

// ===== sv/rand48_byte_whitener_with_reseed_unit.sv =====
// Top level of the rand48 byte whitener with Murmur2 style reseed.
// Uses r48bw_pkg for constants, opcodes and sequencer states.
//
// Channel  | dir | fields (lowest bit first)
// ---------+-----+--------------------------------------------------------------
// s_axis   | in  | tdata: entropy_value[63:0], crank_count[68:64],
//          |     |        data_in[76:69], zero[79:77]; tuser: operation; tlast: last_byte
// m_axis   | out | tdata: out_byte[7:0]; tuser: byte_valid
//
// Multiplier: every product runs through one shared 32x32 multiplier as three
// partial products (low*low, low*high, high*low; the high*high term falls
// outside 2^64). A data byte takes one product, a reseed two, a base mix
// crank_count+3 and an undefined operation none. s_axis_tready is high only
// while the sequencer is idle. Reset clears both seeds and the control state.
// A result waiting on m_axis does not block the next transfer in; only a second
// finished result stalls in the done state until the output register frees.
module rand48_byte_whitener_with_reseed_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entropy_value[63:0], crank_count[68:64], data_in[76:69], zero pad[79:77]
  input  logic [79:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  // byte_valid[0]
  output logic [0:0]  m_axis_tuser
);
  import r48bw_pkg::*;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [SeedW-1:0]  commit_q, commit_d;
  logic [SeedW-1:0]  work_q, work_d;
  logic [WordW-1:0]  opa_q, opa_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic [1:0]        part_q, part_d;
  logic [LoopW-1:0]  loop_q, loop_d;
  logic              hstage_q, hstage_d;
  logic [7:0]        din_q, din_d;
  logic              last_q, last_d;
  logic [7:0]        res_byte_q, res_byte_d;
  logic              res_vld_q, res_vld_d;
  logic              out_vld_q, out_vld_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_flag_q, out_flag_d;

  logic              in_xfer;
  logic              out_free;
  logic [63:0]       in_ev;
  logic [CrankW-1:0] in_crank;
  logic [SeedW-1:0]  base_mix;
  logic [HalfW-1:0]  mul_a, mul_b;
  logic [WordW-1:0]  mul_p;
  logic [WordW-1:0]  mul_const;
  logic [SeedW-1:0]  lcg_x;
  logic [WordW-1:0]  hash_h;
  logic [SeedW-1:0]  hash_x;
  logic              finish;
  logic [7:0]        fin_byte;
  logic              fin_vld;

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign in_ev    = s_axis_tdata[63:0];
  assign in_crank = s_axis_tdata[68:64];

  // Base mix: add each entropy slice, XORed with its constant, into its seed word.
  // No carry passes between words.
  assign base_mix[15:0]  = commit_q[15:0]  + (BaseC0 ^ in_ev[15:0]);
  assign base_mix[31:16] = commit_q[31:16] + (BaseC1 ^ in_ev[31:16]);
  assign base_mix[47:32] = commit_q[47:32] + (BaseC2 ^ in_ev[47:32]);

  // Shared multiplier: one 32x32 partial product per cycle.
  assign mul_const = (op_q == OpReseed) ? HMul : LcgMul;
  assign mul_a     = (part_q == 2'd2) ? opa_q[63:32] : opa_q[31:0];
  assign mul_b     = (part_q == 2'd1) ? mul_const[63:32] : mul_const[31:0];
  assign mul_p     = mul_a * mul_b;

  assign lcg_x  = acc_q[SeedW-1:0] + LcgAdd;
  assign hash_h = HashInit ^ acc_q;
  assign hash_x = hash_h[SeedW-1:0] ^ {32'd0, hash_h[63:48]};

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    commit_d   = commit_q;
    work_d     = work_q;
    opa_d      = opa_q;
    acc_d      = acc_q;
    part_d     = part_q;
    loop_d     = loop_q;
    hstage_d   = hstage_q;
    din_d      = din_q;
    last_d     = last_q;
    res_byte_d = res_byte_q;
    res_vld_d  = res_vld_q;
    finish     = 1'b0;
    fin_byte   = 8'd0;
    fin_vld    = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          op_d       = op_e'(s_axis_tuser);
          din_d      = s_axis_tdata[76:69];
          last_d     = s_axis_tlast;
          part_d     = 2'd0;
          hstage_d   = 1'b0;
          res_byte_d = 8'd0;
          res_vld_d  = 1'b0;
          loop_d     = LoopW'(in_crank) + CrankExtra;
          unique case (op_e'(s_axis_tuser))
            OpBase: begin
              opa_d   = {16'd0, base_mix};
              state_d = StMul;
            end
            OpReseed: begin
              opa_d   = in_ev;
              state_d = StMul;
            end
            OpData: begin
              opa_d   = {16'd0, work_q};
              state_d = StMul;
            end
            OpNone: begin
              state_d = StDone;
            end
          endcase
        end
      end

      StMul: begin
        // Accumulate the product mod 2^64, one partial product a cycle.
        if (part_q == 2'd0) begin
          acc_d = mul_p;
        end else begin
          acc_d = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
        end
        if (part_q == 2'd2) begin
          part_d  = 2'd0;
          state_d = StPost;
        end else begin
          part_d = part_q + 2'd1;
        end
      end

      StPost: begin
        unique case (op_q)
          OpBase: begin
            if (loop_q == LoopW'(1)) begin
              commit_d = lcg_x;
              finish   = 1'b1;
            end else begin
              // Advance the LCG once more.
              opa_d   = {16'd0, lcg_x};
              loop_d  = loop_q - LoopW'(1);
              state_d = StMul;
            end
          end
          OpReseed: begin
            if (!hstage_q) begin
              // Fold the high bits down, then multiply again.
              opa_d    = acc_q ^ (acc_q >> HShift);
              hstage_d = 1'b1;
              state_d  = StMul;
            end else begin
              commit_d = commit_q ^ hash_x;
              work_d   = commit_q ^ hash_x;
              finish   = 1'b1;
            end
          end
          OpData: begin
            work_d   = lcg_x;
            fin_byte = din_q ^ lcg_x[30:23];
            fin_vld  = 1'b1;
            if (last_q) begin
              commit_d[31:0] = lcg_x[31:0];
            end
            finish   = 1'b1;
          end
          OpNone: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          res_byte_d = fin_byte;
          res_vld_d  = fin_vld;
          state_d    = out_free ? StIdle : StDone;
        end
      end

      StDone: begin
        // Hold the result until the output register frees.
        if (out_free) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: load on finish or from the done state, drop on transfer out.
  always_comb begin
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_flag_d = out_flag_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (finish && out_free) begin
      out_vld_d  = 1'b1;
      out_byte_d = fin_byte;
      out_flag_d = fin_vld;
    end else if (state_q == StDone && out_free) begin
      out_vld_d  = 1'b1;
      out_byte_d = res_byte_q;
      out_flag_d = res_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      commit_q  <= '0;
      work_q    <= '0;
      out_vld_q <= 1'b0;
      part_q    <= 2'd0;
      hstage_q  <= 1'b0;
      loop_q    <= '0;
      op_q      <= OpNone;
    end else begin
      state_q   <= state_d;
      commit_q  <= commit_d;
      work_q    <= work_d;
      out_vld_q <= out_vld_d;
      part_q    <= part_d;
      hstage_q  <= hstage_d;
      loop_q    <= loop_d;
      op_q      <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q      <= opa_d;
    acc_q      <= acc_d;
    din_q      <= din_d;
    last_q     <= last_d;
    res_byte_q <= res_byte_d;
    res_vld_q  <= res_vld_d;
    out_byte_q <= out_byte_d;
    out_flag_q <= out_flag_d;
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_byte_q;
  assign m_axis_tuser[0] = out_flag_q;

endmodule
